FILE: hdl/aes_pkg.sv
// AES package: S-box tables, GF(2^8) helpers, register indexes and shared types.
// No dependencies; used by aes_round, aes_block_cipher and the bench.
package aes_pkg;

	localparam int KEY_REGS = 5;

	typedef enum logic [2:0] {
		REG_KEY_SIZE = 3'd0,
		REG_KEY_0    = 3'd1,
		REG_KEY_1    = 3'd2,
		REG_KEY_2    = 3'd3,
		REG_KEY_3    = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		KS_128 = 2'd0,
		KS_192 = 2'd1,
		KS_256 = 2'd2
	} key_size_t;

	typedef struct packed {
		logic        req;
		logic [1:0]  key_size;
		logic [255:0] key;
	} expand_req_t;

	function automatic logic [7:0] xt(input logic [7:0] a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		logic [7:0] p;
		r = 8'h00;
		p = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) r = r ^ p;
			p = xt(p);
		end
		gmul = r;
	endfunction

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	localparam logic [7:0] ISBOX [256] = '{
	8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
	8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
	8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
	8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
	8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
	8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
	8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
	8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
	8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
	8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
	8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
	8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
	8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
	8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
	8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
	8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

endpackage

FILE: hdl/aes_stream_if.sv
// Valid/ready channel carrying op and a 128-bit block (or result) as two 64-bit halves.
// No dependencies.
interface aes_stream_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [63:0] hi;
	logic [63:0] lo;
	modport source (output valid, output op, output hi, output lo, input ready);
	modport sink (input valid, input op, input hi, input lo, output ready);
endinterface

FILE: hdl/aes_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module aes_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 60
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: hdl/aes_round.sv
// Combinational AES round: sub/shift/mix for encrypt, inverse order for decrypt.
// Depends on aes_pkg.
module aes_round (
	input  logic         dec,
	input  logic         first,
	input  logic         last,
	input  logic [127:0] st,
	input  logic [127:0] rk,
	output logic [127:0] nx
);
	import aes_pkg::*;

	logic [7:0] s [16];
	logic [7:0] t [16];
	logic [7:0] m [16];
	logic [7:0] a [16];
	logic [7:0] k [16];

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			s[i] = st[127-8*i -: 8];
			k[i] = rk[127-8*i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (!dec) t[4*c+r] = SBOX[s[4*((c+r)%4)+r]];
				else t[4*((c+r)%4)+r] = ISBOX[s[4*c+r]];
			end
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (!dec)
					m[4*c+r] = xt(t[4*c+r]) ^ xt(t[4*c+(r+1)%4]) ^ t[4*c+(r+1)%4]
						^ t[4*c+(r+2)%4] ^ t[4*c+(r+3)%4];
				else
					m[4*c+r] = 8'h00;
			end
		end
		for (int i = 0; i < 16; i++) a[i] = t[i] ^ k[i];
		if (dec) begin
			for (int c = 0; c < 4; c++) begin
				for (int r = 0; r < 4; r++) begin
					m[4*c+r] = gmul(a[4*c+r], 8'h0e) ^ gmul(a[4*c+(r+1)%4], 8'h0b)
						^ gmul(a[4*c+(r+2)%4], 8'h0d) ^ gmul(a[4*c+(r+3)%4], 8'h09);
				end
			end
		end
		for (int i = 0; i < 16; i++) begin
			if (first) nx[127-8*i -: 8] = s[i] ^ k[i];
			else if (last || dec) nx[127-8*i -: 8] = dec && !last ? m[i] : a[i];
			else nx[127-8*i -: 8] = m[i] ^ k[i];
		end
	end
endmodule

FILE: hdl/aes_block_cipher.sv
// AES cipher top level: APB key registers, key expansion and round sequencer over a
// round-key RAM. Depends on aes_pkg, aes_stream_if, aes_ram and aes_round.
//
//  channel   dir  payload                    transfer
//  in        in   op, hi, lo (128-bit block) valid & ready
//  out       out  hi, lo (128-bit result)    valid & ready
//  apb       in   psel/penable/pwrite write  psel & penable & pwrite
//
// A result is valid once its rounds have run after the input transfer: one round per
// cycle, one 128-bit round-key row read from the RAM per round. The next input transfer
// comes at the earliest in the cycle after the result transfer. After reset or a key
// write the first block waits for the expansion, one word per cycle; a key write during
// it restarts it. A result waits in the output register and holds the input off until
// its transfer.
module aes_block_cipher #(
	parameter int ROUND_KEY_WORDS = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	aes_stream_if.sink   in,
	aes_stream_if.source out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import aes_pkg::*;

	localparam int ROWS = (ROUND_KEY_WORDS + 3) / 4;
	localparam int RW = $clog2(ROWS);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXP  = 5'b00010,
		ST_RD   = 5'b00100,
		ST_RUN  = 5'b01000,
		ST_DONE = 5'b10000
	} st_t;

	st_t          st_q;
	logic [1:0]   ksize_q;
	logic [63:0]  key_q [4];
	logic         ready_q;
	logic [5:0]   wi_q;
	logic [31:0]  win_q [8];
	logic [7:0]   rcon_q;
	logic [2:0]   ph_q;
	logic [127:0] row_acc_q;
	logic [3:0]   rnd_q;
	logic         dec_q;
	logic [127:0] state_q;
	logic         ovalid_q;
	logic [127:0] res_q;

	logic         we;
	logic [RW-1:0] waddr, raddr;
	logic [127:0] wdata, rdata;
	logic [127:0] rkey;
	logic [127:0] nx;
	logic [3:0]   nr, nk, cur;
	logic [2:0]   last_w;
	logic [5:0]   total;
	logic [31:0]  t, neww;
	logic         wr;
	logic         cfg_hit;
	logic [2:0]   ra;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign ra = paddr[5:3];
	assign cfg_hit = wr && (ra <= 3'(KEY_REGS - 1));
	always_comb begin
		unique case (ra)
			REG_KEY_SIZE: prdata = {62'd0, ksize_q};
			REG_KEY_0: prdata = key_q[0];
			REG_KEY_1: prdata = key_q[1];
			REG_KEY_2: prdata = key_q[2];
			REG_KEY_3: prdata = key_q[3];
			default: prdata = 64'd0;
		endcase
	end

	assign nk = 4'(4 + 2 * ksize_q);
	assign nr = 4'(10 + 2 * ksize_q);
	assign total = 6'(4 * (nk + 7));
	assign last_w = 3'(nk - 4'd1);

	// current expansion word from the sliding window of the last Nk words
	always_comb begin
		t = win_q[last_w];
		if (ph_q == 3'd0) t = sub_word({t[23:0], t[31:24]}) ^ {rcon_q, 24'd0};
		else if (nk == 4'd8 && ph_q == 3'd4) t = sub_word(t);
		neww = (wi_q < 6'(nk)) ? (wi_q[0] ? key_q[wi_q[2:1]][31:0] : key_q[wi_q[2:1]][63:32])
			: win_q[0] ^ t;
	end

	assign we = (st_q == ST_EXP) && (wi_q[1:0] == 2'd3) && (int'(wi_q) < 4 * ROWS);
	assign waddr = RW'(wi_q >> 2);
	assign wdata = {row_acc_q[95:0], neww};
	assign cur = dec_q ? 4'(nr - rnd_q) : rnd_q;
	assign raddr = (st_q == ST_IDLE) ? RW'(in.op ? nr : 4'd0) : RW'(cur + (dec_q ? -4'd1 : 4'd1));

	// words past the store read as zero
	always_comb begin
		for (int j = 0; j < 4; j++)
			rkey[127-32*j -: 32] = (4 * int'(cur) + j < ROUND_KEY_WORDS) ?
				rdata[127-32*j -: 32] : 32'd0;
	end

	aes_ram #(.WIDTH(128), .DEPTH(ROWS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	aes_round u_round (
		.dec(dec_q), .first(rnd_q == 4'd0), .last(rnd_q == nr), .st(state_q),
		.rk(rkey), .nx(nx)
	);

	assign in.ready = (st_q == ST_IDLE) && ready_q && !ovalid_q && !wr;
	assign out.valid = ovalid_q;
	assign out.op = 1'b0;
	assign out.hi = res_q[127:64];
	assign out.lo = res_q[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ksize_q <= KS_128;
			ready_q <= 1'b0;
			ovalid_q <= 1'b0;
			wi_q <= '0;
			rnd_q <= '0;
			ph_q <= '0;
			rcon_q <= 8'h01;
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
		end else begin
			if (out.valid && out.ready) ovalid_q <= 1'b0;
			if (wr) begin
				unique case (ra)
					REG_KEY_SIZE: ksize_q <= pwdata[1:0] == 2'd3 ? KS_256 : pwdata[1:0];
					REG_KEY_0: key_q[0] <= pwdata;
					REG_KEY_1: key_q[1] <= pwdata;
					REG_KEY_2: key_q[2] <= pwdata;
					REG_KEY_3: key_q[3] <= pwdata;
					default: ;
				endcase
			end
			if (cfg_hit) ready_q <= 1'b0;
			else if (st_q == ST_EXP && wi_q == total - 6'd1) ready_q <= 1'b1;
			unique case (st_q)
				ST_IDLE: begin
					if (!ready_q && !wr) begin
						st_q <= ST_EXP;
						wi_q <= '0;
						ph_q <= '0;
						rcon_q <= 8'h01;
					end else if (in.valid && in.ready) begin
						dec_q <= in.op;
						state_q <= {in.hi, in.lo};
						rnd_q <= '0;
						st_q <= ST_RUN;
					end
				end
				ST_EXP: begin
					if (cfg_hit) begin
						st_q <= ST_IDLE;
					end else begin
						row_acc_q <= wdata;
						for (int i = 0; i < 7; i++) begin
							if (i == int'(last_w)) win_q[i] <= neww;
							else if (i < int'(last_w)) win_q[i] <= win_q[i+1];
						end
						if (last_w == 3'd7) win_q[7] <= neww;
						if (wi_q >= 6'(nk)) begin
							ph_q <= (ph_q == 3'(nk - 1)) ? 3'd0 : ph_q + 3'd1;
							if (ph_q == 3'd0) rcon_q <= xt(rcon_q);
						end
						wi_q <= wi_q + 6'd1;
						if (wi_q == total - 6'd1) st_q <= ST_IDLE;
					end
				end
				ST_RUN: begin
					state_q <= nx;
					rnd_q <= rnd_q + 4'd1;
					if (rnd_q == nr) begin
						res_q <= nx;
						ovalid_q <= 1'b1;
						st_q <= ST_IDLE;
					end
				end
				ST_RD, ST_DONE: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: bench/aes_block_cipher_tb.sv
// Self-checking bench for aes_block_cipher: AES-128/192/256 encrypt and decrypt blocks
// checked by a bench model or known answers. Depends on aes_pkg, aes_stream_if and the RTL.
module aes_block_cipher_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import aes_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd5;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic        wr;
		logic [2:0]  idx;
		logic [63:0] data;
		logic        op;
		logic [63:0] hi;
		logic [63:0] lo;
		logic        typed;
		logic [63:0] exp_hi;
		logic [63:0] exp_lo;
	} vec_t;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
	} block_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	aes_stream_if in_ch ();
	aes_stream_if out_ch ();

	aes_block_cipher u_top (
		.clk(clk), .arst_n(arst_n), .in(in_ch), .out(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// bench copy of the key registers and schedule
	logic [1:0]  ks_model;
	logic [63:0] key_model [4];
	logic [31:0] sched [60];
	logic        sched_valid;

	block_t      pending_results [$];
	int          errors;
	int          cycles;
	logic        idle_on;
	logic        long_hold;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] p;
		logic [7:0] r;
		p = {1'b0, a};
		r = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) r ^= p[7:0];
			p = p << 1;
			if (p[8]) p ^= 9'h11b;
		end
		return r;
	endfunction

	function automatic logic [7:0] gf_inverse(input logic [7:0] a);
		logic [7:0] r;
		logic [7:0] p;
		r = 8'h01;
		p = a;
		for (int i = 0; i < 7; i++) begin
			p = gf_mult(p, p);
			r = gf_mult(r, p);
		end
		return r;
	endfunction

	function automatic logic [7:0] rot8(input logic [7:0] x, input int n);
		return (x << n) | (x >> (8 - n));
	endfunction

	function automatic logic [7:0] fwd_sub(input logic [7:0] x);
		logic [7:0] b;
		b = gf_inverse(x);
		return b ^ rot8(b, 1) ^ rot8(b, 2) ^ rot8(b, 3) ^ rot8(b, 4) ^ 8'h63;
	endfunction

	function automatic logic [7:0] inv_sub(input logic [7:0] x);
		return gf_inverse(rot8(x, 1) ^ rot8(x, 3) ^ rot8(x, 6) ^ 8'h05);
	endfunction

	function automatic logic [31:0] sub_bytes_word(input logic [31:0] w);
		return {fwd_sub(w[31:24]), fwd_sub(w[23:16]), fwd_sub(w[15:8]), fwd_sub(w[7:0])};
	endfunction

	function automatic void write_reg_model(input logic [2:0] idx, input logic [63:0] v);
		if (idx == REG_KEY_SIZE) begin
			ks_model = (v[1:0] == 2'd3) ? KS_256 : v[1:0];
			sched_valid = 1'b0;
		end else if (idx <= REG_KEY_3) begin
			key_model[2'(idx - 3'd1)] = v;
			sched_valid = 1'b0;
		end
	endfunction

	function automatic void expand_schedule();
		int nk;
		int total;
		logic [7:0] rc;
		logic [31:0] t;
		nk = 4 + 2 * ks_model;
		total = 4 * (nk + 7);
		rc = 8'h01;
		for (int i = 0; i < nk; i++)
			sched[i] = i[0] ? key_model[2'((i >> 1) & 3)][31:0]
				: key_model[2'((i >> 1) & 3)][63:32];
		for (int i = nk; i < total; i++) begin
			t = sched[i - 1];
			if (i % nk == 0) begin
				t = sub_bytes_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = gf_mult(rc, 8'h02);
			end else if (nk > 6 && i % nk == 4) begin
				t = sub_bytes_word(t);
			end
			sched[i] = sched[i - nk] ^ t;
		end
		sched_valid = 1'b1;
	endfunction

	function automatic block_t cipher_block(input logic dec, input logic [63:0] hi,
			input logic [63:0] lo);
		logic [7:0] s [16];
		logic [7:0] n [16];
		logic [7:0] m [4];
		logic [7:0] acc;
		logic [31:0] w;
		block_t res;
		int nr;
		int rnd;
		if (!sched_valid) expand_schedule();
		nr = 10 + 2 * ks_model;
		for (int i = 0; i < 8; i++) begin
			s[i] = hi[63 - 8 * i -: 8];
			s[8 + i] = lo[63 - 8 * i -: 8];
		end
		if (dec) begin
			m[0] = 8'h0e;
			m[1] = 8'h0b;
			m[2] = 8'h0d;
			m[3] = 8'h09;
		end else begin
			m[0] = 8'h02;
			m[1] = 8'h03;
			m[2] = 8'h01;
			m[3] = 8'h01;
		end
		for (int step = 0; step <= nr; step++) begin
			rnd = dec ? nr - step : step;
			if (step > 0) begin
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						if (dec) n[4 * ((c + r) & 3) + r] = s[4 * c + r];
						else n[4 * c + r] = s[4 * ((c + r) & 3) + r];
				for (int i = 0; i < 16; i++)
					s[i] = dec ? inv_sub(n[i]) : fwd_sub(n[i]);
				if (!dec && step < nr) begin
					for (int c = 0; c < 4; c++)
						for (int r = 0; r < 4; r++) begin
							acc = 8'h00;
							for (int k = 0; k < 4; k++)
								acc ^= gf_mult(s[4 * c + k], m[(k - r) & 3]);
							n[4 * c + r] = acc;
						end
					s = n;
				end
			end
			for (int c = 0; c < 4; c++) begin
				w = sched[4 * rnd + c];
				for (int r = 0; r < 4; r++)
					s[4 * c + r] ^= w[31 - 8 * r -: 8];
			end
			if (dec && step > 0 && step < nr) begin
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++) begin
						acc = 8'h00;
						for (int k = 0; k < 4; k++)
							acc ^= gf_mult(s[4 * c + k], m[(k - r) & 3]);
						n[4 * c + r] = acc;
					end
				s = n;
			end
		end
		for (int i = 0; i < 8; i++) begin
			res.hi[63 - 8 * i -: 8] = s[i];
			res.lo[63 - 8 * i -: 8] = s[8 + i];
		end
		return res;
	endfunction

	task automatic reg_write(input logic [2:0] idx, input logic [63:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		write_reg_model(idx, v);
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_block(input logic dec, input logic [63:0] hi, input logic [63:0] lo,
			input logic typed, input logic [63:0] eh, input logic [63:0] el);
		block_t exp_blk;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= dec;
		in_ch.hi <= hi;
		in_ch.lo <= lo;
		do @(posedge clk); while (!in_ch.ready);
		exp_blk = cipher_block(dec, hi, lo);
		if (typed) begin
			exp_blk.hi = eh;
			exp_blk.lo = el;
		end
		pending_results.push_back(exp_blk);
	endtask

	task automatic finish_items();
		@(posedge clk);
		in_ch.valid <= 1'b0;
		drain();
	endtask

	function automatic logic [63:0] rand64();
		case ($urandom_range(0, 5))
			0: return 64'h0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("aes_block_cipher verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected: %h %h", out_ch.hi, out_ch.lo);
				errors++;
			end else begin
				if (out_ch.hi !== pending_results[0].hi) begin
					$error("result_high expected %h actual %h", pending_results[0].hi, out_ch.hi);
					errors++;
				end
				if (out_ch.lo !== pending_results[0].lo) begin
					$error("result_low expected %h actual %h", pending_results[0].lo, out_ch.lo);
					errors++;
				end
				void'(pending_results.pop_front());
			end
		end
	end

	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
				long_hold = 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	vec_t dir [] = '{
		'{0, REG_KEY_SIZE, 0, 0, 64'h0, 64'h0, 1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
		'{0, REG_KEY_SIZE, 0, 1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1, 64'h0, 64'h0},
		'{0, REG_KEY_SIZE, 0, 0, '1, '1, 0, 0, 0},
		'{0, REG_KEY_SIZE, 0, 1, '1, '1, 0, 0, 0},
		'{0, REG_KEY_SIZE, 0, 0, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 0, 0, 0},
		'{1, REG_KEY_0, 64'h0001020304050607, 0, 0, 0, 0, 0, 0},
		'{1, REG_KEY_1, 64'h08090a0b0c0d0e0f, 0, 0, 0, 0, 0, 0},
		'{1, REG_KEY_2, 64'h1011121314151617, 0, 0, 0, 0, 0, 0},
		'{1, REG_KEY_3, 64'h18191a1b1c1d1e1f, 0, 0, 0, 0, 0, 0},
		'{0, REG_KEY_SIZE, 0, 0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1,
			64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
		'{0, REG_KEY_SIZE, 0, 1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1,
			64'h0011223344556677, 64'h8899aabbccddeeff},
		'{1, REG_KEY_SIZE, 64'(KS_192), 0, 0, 0, 0, 0, 0},
		'{0, REG_KEY_SIZE, 0, 0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1,
			64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191},
		'{0, REG_KEY_SIZE, 0, 1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191, 1,
			64'h0011223344556677, 64'h8899aabbccddeeff},
		'{1, REG_KEY_SIZE, 64'h3, 0, 0, 0, 0, 0, 0},
		'{0, REG_KEY_SIZE, 0, 0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1,
			64'h8ea2b7ca516745bf, 64'heafc49904b496089},
		'{1, REG_UNUSED, '1, 0, 0, 0, 0, 0, 0},
		'{0, REG_KEY_SIZE, 0, 1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1,
			64'h0011223344556677, 64'h8899aabbccddeeff},
		'{1, REG_KEY_SIZE, 64'(KS_256), 0, 0, 0, 0, 0, 0},
		'{1, REG_KEY_0, '1, 0, 0, 0, 0, 0, 0},
		'{1, REG_KEY_3, '1, 0, 0, 0, 0, 0, 0},
		'{0, REG_KEY_SIZE, 0, 0, '1, '1, 0, 0, 0},
		'{0, REG_KEY_SIZE, 0, 1, 64'h0, 64'h0, 0, 0, 0}
	};

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.op = 1'b0;
		in_ch.hi = '0;
		in_ch.lo = '0;
		errors = 0;
		cycles = 0;
		idle_on = 1'b1;
		long_hold = 1'b0;
		ks_model = KS_128;
		foreach (key_model[i]) key_model[i] = '0;
		sched_valid = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir[i]) begin
			if (dir[i].wr) begin
				finish_items();
				reg_write(dir[i].idx, dir[i].data);
			end else begin
				send_block(dir[i].op, dir[i].hi, dir[i].lo, dir[i].typed,
					dir[i].exp_hi, dir[i].exp_lo);
			end
		end
		finish_items();

		for (int ph = 0; ph < 8; ph++) begin
			idle_on = (ph != 7);
			reg_write(REG_KEY_SIZE, (ph == 6) ? 64'h3 : 64'(ph % 3));
			for (int k = REG_KEY_0; k <= REG_KEY_3; k++)
				reg_write(k[2:0], rand64());
			if (ph == 2) reg_write(REG_UNUSED + 3'd2, rand64());
			for (int n = 0; n < 115; n++) begin
				if (ph == 3 && n == 20) long_hold = 1'b1;
				if (ph == 5 && n == 60) finish_items();
				send_block(1'($urandom_range(0, 1)), rand64(), rand64(), 1'b0, '0, '0);
			end
			finish_items();
		end

		repeat (40) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("aes_block_cipher verification clean");
		else
			$display("aes_block_cipher verification failed");
		$finish;
	end
endmodule
